### design/ps2md_pkg.sv
// Package for the PS/2 mouse packet decoder: status and header bit positions,
// field widths and the packet byte position type. No dependencies.
`default_nettype none

package ps2md_pkg;

    localparam int STATUS_READY_BIT = 0;
    localparam int STATUS_AUX_BIT   = 5;

    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    localparam int BYTE_W   = 8;
    localparam int MOVE_X_W = 7;
    localparam int MOVE_Y_W = 6;

    // 9-bit movement plus a remainder of SHIFT+1 bits, with sign
    localparam int SUM_W = 10;

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } byte_pos_t;

endpackage

`default_nettype wire

### design/ps2_mouse_packet_decoder.sv
// PS/2 mouse three-byte packet decoder with scaled cursor moves.
// Depends on ps2md_pkg (bit positions, widths, byte position type).
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   request | req_valid req_ready port_status | in
//           | data_byte                       |
//   move    | move_valid move_ready move_x    | out
//           | move_y                          |
//
// One request per cycle unless a move is held by a stalled move output.
// The request register feeds one pass of packet and divide logic into the
// move register; requests that make no move pass even while move stalls.
// Reset clears both valid flags, packet position, header, X byte and both remainders.
`default_nettype none

module ps2_mouse_packet_decoder
    import ps2md_pkg::*;
#(
    parameter int X_SHIFT = 3,
    parameter int Y_SHIFT = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic [BYTE_W-1:0]           port_status,
    input  wire logic [BYTE_W-1:0]           data_byte,
    output logic                             move_valid,
    input  wire logic                        move_ready,
    output logic signed [MOVE_X_W-1:0]       move_x,
    output logic signed [MOVE_Y_W-1:0]       move_y
);

    localparam int XR_W = X_SHIFT + 1;
    localparam int YR_W = Y_SHIFT + 1;

    localparam logic signed [SUM_W-1:0] X_BIAS = SUM_W'((1 << X_SHIFT) - 1);
    localparam logic signed [SUM_W-1:0] Y_BIAS = SUM_W'((1 << Y_SHIFT) - 1);
    localparam logic signed [SUM_W-1:0] X_MIN  = SUM_W'(-(2 ** (MOVE_X_W - 1)));
    localparam logic signed [SUM_W-1:0] X_MAX  = SUM_W'((2 ** (MOVE_X_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] Y_MIN  = SUM_W'(-(2 ** (MOVE_Y_W - 1)));
    localparam logic signed [SUM_W-1:0] Y_MAX  = SUM_W'((2 ** (MOVE_Y_W - 1)) - 1);

    logic                      stage_valid_reg;
    logic [BYTE_W-1:0]         stage_status_reg;
    logic [BYTE_W-1:0]         stage_data_reg;

    byte_pos_t                 pos_reg, pos_next;
    logic [BYTE_W-1:0]         header_reg, header_next;
    logic [BYTE_W-1:0]         x_byte_reg, x_byte_next;
    logic signed [XR_W-1:0]    x_rem_reg, x_rem_next;
    logic signed [YR_W-1:0]    y_rem_reg, y_rem_next;

    logic                      move_valid_reg;
    logic signed [MOVE_X_W-1:0] move_x_reg;
    logic signed [MOVE_Y_W-1:0] move_y_reg;

    logic                      byte_used;
    logic                      packet_done;
    logic                      produce;
    logic                      out_free;
    logic                      advance;

    logic signed [SUM_W-1:0]   dx, dy, sx, sy, qx, qy, nqy, rx, ry, sat_x, sat_y;

    assign byte_used = stage_status_reg[STATUS_READY_BIT] && stage_status_reg[STATUS_AUX_BIT];
    assign out_free  = !move_valid_reg || move_ready;
    assign advance   = stage_valid_reg && (!produce || out_free);
    assign req_ready = !stage_valid_reg || advance;

    // movement arithmetic for the third packet byte
    always_comb
    begin
        dx  = {{(SUM_W - BYTE_W){header_reg[HDR_XSIGN_BIT]}}, x_byte_reg};
        dy  = {{(SUM_W - BYTE_W){header_reg[HDR_YSIGN_BIT]}}, stage_data_reg};
        sx  = dx + SUM_W'(x_rem_reg);
        sy  = dy + SUM_W'(y_rem_reg);
        qx  = (sx + (sx[SUM_W-1] ? X_BIAS : SUM_W'(0))) >>> X_SHIFT;
        qy  = (sy + (sy[SUM_W-1] ? Y_BIAS : SUM_W'(0))) >>> Y_SHIFT;
        rx  = sx - (qx <<< X_SHIFT);
        ry  = sy - (qy <<< Y_SHIFT);
        nqy = -qy;
        sat_x = (qx < X_MIN) ? X_MIN : ((qx > X_MAX) ? X_MAX : qx);
        sat_y = (nqy < Y_MIN) ? Y_MIN : ((nqy > Y_MAX) ? Y_MAX : nqy);
    end

    always_comb
    begin
        pos_next    = pos_reg;
        header_next = header_reg;
        x_byte_next = x_byte_reg;
        x_rem_next  = x_rem_reg;
        y_rem_next  = y_rem_reg;
        packet_done = 1'b0;
        if (byte_used)
        begin
            unique case (pos_reg)
                POS_HEADER:
                begin
                    if (stage_data_reg[HDR_SYNC_BIT])
                    begin
                        header_next = stage_data_reg;
                        pos_next    = POS_X;
                    end
                end
                POS_X:
                begin
                    x_byte_next = stage_data_reg;
                    pos_next    = POS_Y;
                end
                default:
                begin
                    packet_done = 1'b1;
                    pos_next    = POS_HEADER;
                    x_rem_next  = rx[XR_W-1:0];
                    y_rem_next  = ry[YR_W-1:0];
                end
            endcase
        end
        produce = packet_done && ((qx != '0) || (qy != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            stage_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            stage_status_reg <= port_status;
            stage_data_reg   <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HEADER;
            header_reg <= '0;
            x_byte_reg <= '0;
            x_rem_reg  <= '0;
            y_rem_reg  <= '0;
        end
        else if (advance)
        begin
            pos_reg    <= pos_next;
            header_reg <= header_next;
            x_byte_reg <= x_byte_next;
            x_rem_reg  <= x_rem_next;
            y_rem_reg  <= y_rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            move_valid_reg <= advance && produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && produce)
        begin
            move_x_reg <= sat_x[MOVE_X_W-1:0];
            move_y_reg <= sat_y[MOVE_Y_W-1:0];
        end
    end

    assign move_valid = move_valid_reg;
    assign move_x     = move_x_reg;
    assign move_y     = move_y_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 2'd3)
        else $error("byte position left 0..2");

    a_move_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        move_valid_reg |-> (move_x_reg != '0 || move_y_reg != '0))
        else $error("zero move emitted");

    a_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && byte_used && pos_reg == POS_HEADER && !stage_data_reg[HDR_SYNC_BIT])
        |=> pos_reg == POS_HEADER)
        else $error("unsynchronized header byte accepted");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (stage_valid_reg && produce && move_valid_reg && !move_ready))
        else $error("request stalled without a blocked move");

    a_move_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (move_valid_reg && !move_ready) |=> ($stable(move_x_reg) && $stable(move_y_reg)))
        else $error("stalled move changed");
`endif

endmodule

`default_nettype wire
